>>> rtl/load_based_frequency_governor_macros.svh
// ---------------------------------------------------------------------------
// load_based_frequency_governor_macros.svh
// assertion macros shared by the governor modules
// ---------------------------------------------------------------------------
`ifndef LOAD_BASED_FREQUENCY_GOVERNOR_MACROS_SVH
`define LOAD_BASED_FREQUENCY_GOVERNOR_MACROS_SVH

// same-cycle implication, off during reset
`define LBFG_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define LBFG_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// invariant that holds at every edge out of reset
`define LBFG_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

`endif

>>> rtl/lbfg_pkg.sv
// ---------------------------------------------------------------------------
// lbfg_pkg
// shared types, constants and constant dividers of the frequency governor
// ---------------------------------------------------------------------------
package lbfg_pkg;

  // field widths
  localparam int TIME_W = 64;
  localparam int FREQ_W = 24;
  localparam int LOAD_W = 7;
  localparam int DLY_W  = 5;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int NUM_W  = TIME_W + LOAD_W;

  // governor constants
  localparam logic [2:0]        HOLD_LIMIT = 3'd5;
  localparam logic [7:0]        HEAT_LIMIT = 8'd20;
  localparam logic [7:0]        HEAT_MAX   = 8'd255;
  localparam logic [LOAD_W-1:0] LOAD_SCALE = 7'd100;
  localparam logic [LOAD_W-1:0] CAP_PCT    = 7'd95;
  localparam logic [DLY_W-1:0]  DELAY_FAST = 5'd10;
  localparam logic [DLY_W-1:0]  DELAY_SLOW = 5'd20;

  // one step per bit of the load scale, used by both the multiply and divide
  localparam logic [2:0] LAST_STEP = 3'd6;

  // reciprocals: ceil(2^38/100) exact below 2^31, ceil(2^24/5) exact below 2^22
  localparam logic [31:0] RECIP100 = 32'd2748779070;
  localparam logic [21:0] RECIP5   = 22'd3355444;

  // register reset values
  localparam logic [LOAD_W-1:0] BIG_TARGET_RST    = 7'd80;
  localparam logic [LOAD_W-1:0] LITTLE_TARGET_RST = 7'd90;
  localparam logic [LOAD_W-1:0] FAST_RAMP_RST     = 7'd90;

  // register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_BIG_TARGET    = 3'd0,
    REG_LITTLE_TARGET = 3'd1,
    REG_FAST_RAMP     = 3'd2,
    REG_LIMIT_MAX     = 3'd3,
    REG_LIMIT_MIN     = 3'd4,
    REG_HW_MAX        = 3'd5,
    REG_HW_MIN        = 3'd6
  } reg_idx_t;

  // controller states
  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_DIFF  = 10'b00_0000_0010,
    S_CHECK = 10'b00_0000_0100,
    S_MUL   = 10'b00_0000_1000,
    S_DIV   = 10'b00_0001_0000,
    S_CLASS = 10'b00_0010_0000,
    S_PROD  = 10'b00_0100_0000,
    S_QUOT  = 10'b00_1000_0000,
    S_PICK  = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic [LOAD_W-1:0] big_target;
    logic [LOAD_W-1:0] little_target;
    logic [LOAD_W-1:0] fast_ramp;
    logic [FREQ_W-1:0] lim_max;
    logic [FREQ_W-1:0] lim_min;
    logic [FREQ_W-1:0] hw_max;
    logic [FREQ_W-1:0] hw_min;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic       capture;
    logic       diff;
    logic       check;
    logic       mul;
    logic       div;
    logic       classify;
    logic       prod;
    logic       quot;
    logic       pick;
    logic       commit;
    logic [2:0] step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic has_prior;
    logic out_free;
  } status_t;

  // floor(x / 100) for x below 2^31
  function automatic logic [24:0] div100(input logic [30:0] x);
    logic [62:0] p;
    p = {32'd0, x} * {31'd0, RECIP100};
    return p[62:38];
  endfunction

  // floor(x / 20) = floor(floor(x / 4) / 5)
  function automatic logic [19:0] div20(input logic [FREQ_W-1:0] x);
    logic [43:0] p;
    p = {22'd0, x[23:2]} * {22'd0, RECIP5};
    return p[43:24];
  endfunction

endpackage

>>> rtl/load_based_frequency_governor.sv
// ---------------------------------------------------------------------------
// load_based_frequency_governor
// load-driven frequency target with hold and heat limits
//
//   port group    direction  handshake             payload
//   sample in     in         in_valid / in_ready   wall_time idle_total cpu_freq
//   result out    out        out_valid / out_ready primed request_valid
//                                                  requested_freq load_percent
//                                                  poll_delay
//   config        in/out     psel penable pwrite   paddr pwdata prdata pready
//
// a sample passes diff, check, multiply, divide, classify, product, quotient
// and pick before its result sits in the output register; the 64-bit load
// divide (7 multiply and 7 divide steps) is longest; priming samples skip all.
// one sample is worked on at a time; a held result stalls the next commit.
// reset is synchronous; config writes take effect at once and hold no item.
// ---------------------------------------------------------------------------
module load_based_frequency_governor (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lbfg_pkg::TIME_W-1:0]         wall_time,
  input  logic [lbfg_pkg::TIME_W-1:0]         idle_total,
  input  logic [lbfg_pkg::FREQ_W-1:0]         cpu_freq,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                primed,
  output logic                                request_valid,
  output logic [lbfg_pkg::FREQ_W-1:0]         requested_freq,
  output logic [lbfg_pkg::LOAD_W-1:0]         load_percent,
  output logic [lbfg_pkg::DLY_W-1:0]          poll_delay,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lbfg_pkg::ADDR_W-1:0]         paddr,
  input  logic [lbfg_pkg::DATA_W-1:0]         pwdata,
  output logic [lbfg_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  lbfg_pkg::cfg_t    cfg;
  lbfg_pkg::cmd_t    cmd;
  lbfg_pkg::status_t status;

  // configuration registers
  lbfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer
  lbfg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  lbfg_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg            (cfg),
    .wall_time      (wall_time),
    .idle_total     (idle_total),
    .cpu_freq       (cpu_freq),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .primed         (primed),
    .request_valid  (request_valid),
    .requested_freq (requested_freq),
    .load_percent   (load_percent),
    .poll_delay     (poll_delay)
  );

endmodule

>>> rtl/lbfg_regs.sv
// ---------------------------------------------------------------------------
// lbfg_regs
// configuration registers behind a simple APB-style port
// ---------------------------------------------------------------------------
module lbfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lbfg_pkg::ADDR_W-1:0]   paddr,
  input  logic [lbfg_pkg::DATA_W-1:0]   pwdata,
  output logic [lbfg_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output lbfg_pkg::cfg_t                cfg
);

  lbfg_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = lbfg_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.big_target    <= lbfg_pkg::BIG_TARGET_RST;
      cfg.little_target <= lbfg_pkg::LITTLE_TARGET_RST;
      cfg.fast_ramp     <= lbfg_pkg::FAST_RAMP_RST;
      cfg.lim_max       <= '0;
      cfg.lim_min       <= '0;
      cfg.hw_max        <= '0;
      cfg.hw_min        <= '0;
    end else if (wr_en) begin
      unique case (idx)
        lbfg_pkg::REG_BIG_TARGET:    cfg.big_target    <= pwdata[6:0];
        lbfg_pkg::REG_LITTLE_TARGET: cfg.little_target <= pwdata[6:0];
        lbfg_pkg::REG_FAST_RAMP:     cfg.fast_ramp     <= pwdata[6:0];
        lbfg_pkg::REG_LIMIT_MAX:     cfg.lim_max       <= pwdata[23:0];
        lbfg_pkg::REG_LIMIT_MIN:     cfg.lim_min       <= pwdata[23:0];
        lbfg_pkg::REG_HW_MAX:        cfg.hw_max        <= pwdata[23:0];
        lbfg_pkg::REG_HW_MIN:        cfg.hw_min        <= pwdata[23:0];
        default: begin
        end
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      lbfg_pkg::REG_BIG_TARGET:    prdata = {25'd0, cfg.big_target};
      lbfg_pkg::REG_LITTLE_TARGET: prdata = {25'd0, cfg.little_target};
      lbfg_pkg::REG_FAST_RAMP:     prdata = {25'd0, cfg.fast_ramp};
      lbfg_pkg::REG_LIMIT_MAX:     prdata = {8'd0, cfg.lim_max};
      lbfg_pkg::REG_LIMIT_MIN:     prdata = {8'd0, cfg.lim_min};
      lbfg_pkg::REG_HW_MAX:        prdata = {8'd0, cfg.hw_max};
      lbfg_pkg::REG_HW_MIN:        prdata = {8'd0, cfg.hw_min};
      default:                     prdata = '0;
    endcase
  end

endmodule

>>> rtl/lbfg_ctrl.sv
// ---------------------------------------------------------------------------
// lbfg_ctrl
// sequencer that walks one sample through the datapath steps
// ---------------------------------------------------------------------------
`include "load_based_frequency_governor_macros.svh"

module lbfg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lbfg_pkg::status_t status,
  output lbfg_pkg::cmd_t    cmd
);

  lbfg_pkg::state_t state, state_next;
  logic [2:0]       step, step_next;
  logic             last;

  assign last     = (step == lbfg_pkg::LAST_STEP);
  assign in_ready = (state == lbfg_pkg::S_IDLE);

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbfg_pkg::S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    step_next  = '0;
    unique case (state)
      lbfg_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = status.has_prior ? lbfg_pkg::S_DIFF : lbfg_pkg::S_OUT;
        end
      end
      lbfg_pkg::S_DIFF:  state_next = lbfg_pkg::S_CHECK;
      lbfg_pkg::S_CHECK: state_next = lbfg_pkg::S_MUL;
      lbfg_pkg::S_MUL: begin
        if (last) begin
          state_next = lbfg_pkg::S_DIV;
        end else begin
          step_next = step + 3'd1;
        end
      end
      lbfg_pkg::S_DIV: begin
        if (last) begin
          state_next = lbfg_pkg::S_CLASS;
        end else begin
          step_next = step + 3'd1;
        end
      end
      lbfg_pkg::S_CLASS: state_next = lbfg_pkg::S_PROD;
      lbfg_pkg::S_PROD:  state_next = lbfg_pkg::S_QUOT;
      lbfg_pkg::S_QUOT:  state_next = lbfg_pkg::S_PICK;
      lbfg_pkg::S_PICK:  state_next = lbfg_pkg::S_OUT;
      lbfg_pkg::S_OUT: begin
        if (status.out_free) begin
          state_next = lbfg_pkg::S_IDLE;
        end
      end
      default: state_next = lbfg_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd          = '0;
    cmd.capture  = (state == lbfg_pkg::S_IDLE) && in_valid;
    cmd.diff     = (state == lbfg_pkg::S_DIFF);
    cmd.check    = (state == lbfg_pkg::S_CHECK);
    cmd.mul      = (state == lbfg_pkg::S_MUL);
    cmd.div      = (state == lbfg_pkg::S_DIV);
    cmd.classify = (state == lbfg_pkg::S_CLASS);
    cmd.prod     = (state == lbfg_pkg::S_PROD);
    cmd.quot     = (state == lbfg_pkg::S_QUOT);
    cmd.pick     = (state == lbfg_pkg::S_PICK);
    cmd.commit   = (state == lbfg_pkg::S_OUT) && status.out_free;
    cmd.step     = step;
  end

  // checks
  `LBFG_ASSERT_NXT(a_primed_goes_diff, clk, rst,
    in_valid && in_ready && status.has_prior, state == lbfg_pkg::S_DIFF,
    "sample after priming did not start the load computation")
  `LBFG_ASSERT_NXT(a_div_ends, clk, rst,
    state == lbfg_pkg::S_DIV && last, state == lbfg_pkg::S_CLASS,
    "divide did not finish after seven steps")
  `LBFG_ASSERT_IMP(a_commit_free, clk, rst,
    cmd.commit, status.out_free,
    "result committed while output register held an item")

endmodule

>>> rtl/lbfg_dp.sv
// ---------------------------------------------------------------------------
// lbfg_dp
// datapath: interval, serial load divider, target selection and state
// ---------------------------------------------------------------------------
`include "load_based_frequency_governor_macros.svh"

module lbfg_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  lbfg_pkg::cmd_t                      cmd,
  output lbfg_pkg::status_t                   status,
  input  lbfg_pkg::cfg_t                      cfg,
  input  logic [lbfg_pkg::TIME_W-1:0]         wall_time,
  input  logic [lbfg_pkg::TIME_W-1:0]         idle_total,
  input  logic [lbfg_pkg::FREQ_W-1:0]         cpu_freq,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                primed,
  output logic                                request_valid,
  output logic [lbfg_pkg::FREQ_W-1:0]         requested_freq,
  output logic [lbfg_pkg::LOAD_W-1:0]         load_percent,
  output logic [lbfg_pkg::DLY_W-1:0]          poll_delay
);

  // captured sample
  logic [lbfg_pkg::TIME_W-1:0] wall_r, idle_r;
  logic [lbfg_pkg::FREQ_W-1:0] cur_r;
  logic                        prime_r;

  // governor state
  logic                        has_prior;
  logic [lbfg_pkg::TIME_W-1:0] last_wall, last_idle;
  logic [lbfg_pkg::FREQ_W-1:0] last_target;
  logic [7:0]                  heat;
  logic [2:0]                  hold;

  // load computation
  logic [lbfg_pkg::TIME_W-1:0] dw, di, busy;
  logic                        bad, big;
  logic [lbfg_pkg::NUM_W-1:0]  num, dsr;
  logic [lbfg_pkg::LOAD_W-1:0] quo, load_r;
  logic [lbfg_pkg::TIME_W:0]   dd;
  logic                        ge;

  // target computation
  logic                        fast, med, cur_gt_mn;
  logic [30:0]                 prod, mx95;
  logic [lbfg_pkg::FREQ_W-1:0] cm, adj, cap, step_a, tp;
  logic [19:0]                 step_b;
  logic [24:0]                 q_adj, q_cap, q_a;
  logic [19:0]                 q_b;
  logic [2:0]                  hold_nx, hold_pick;
  logic [lbfg_pkg::DLY_W-1:0]  delay_r;
  logic [lbfg_pkg::LOAD_W-1:0] thr;
  logic [lbfg_pkg::FREQ_W-1:0] dec_step, tp_pick;
  logic [lbfg_pkg::FREQ_W:0]   floor_sum;

  // final stage
  logic                        at_max;
  logic [7:0]                  heat_inc, heat_nx;
  logic [lbfg_pkg::FREQ_W-1:0] tgt;
  logic                        req;

  assign status.has_prior = has_prior;
  assign status.out_free  = !out_valid || out_ready;

  // interval check and divider compare
  assign dd = {1'b0, dw} - {1'b0, di};
  assign ge = (num >= dsr);

  // constant dividers
  assign q_adj = lbfg_pkg::div100(prod);
  assign q_cap = lbfg_pkg::div100(mx95);
  assign q_a   = lbfg_pkg::div100({7'd0, cfg.lim_min});
  assign q_b   = lbfg_pkg::div20(cm);

  assign thr = big ? cfg.big_target : cfg.little_target;

  // target choice by load band
  always_comb begin
    dec_step  = (step_a > {4'd0, step_b}) ? step_a : {4'd0, step_b};
    floor_sum = {1'b0, cfg.lim_min} + {1'b0, dec_step};
    hold_pick = hold;
    if (fast) begin
      tp_pick = cfg.lim_max;
      if (hold < lbfg_pkg::HOLD_LIMIT) begin
        hold_pick = hold + 3'd1;
      end
    end else if (med) begin
      tp_pick = (adj > cur_r) ? adj : cur_r;
    end else if (hold != 3'd0) begin
      tp_pick   = cur_r;
      hold_pick = hold - 3'd1;
    end else if (cur_gt_mn) begin
      tp_pick = ({1'b0, cur_r} > floor_sum) ? cur_r - dec_step : cfg.lim_min;
    end else begin
      tp_pick = cfg.lim_min;
    end
  end

  // heat tracking and cap
  always_comb begin
    at_max   = (tp >= cfg.lim_max);
    heat_inc = (heat != lbfg_pkg::HEAT_MAX) ? heat + 8'd1 : heat;
    tgt      = tp;
    heat_nx  = heat;
    if (at_max) begin
      heat_nx = heat_inc;
      if (heat_inc > lbfg_pkg::HEAT_LIMIT) begin
        tgt = cap;
      end
    end else if (heat != 8'd0) begin
      heat_nx = heat - 8'd1;
    end
    req = (tgt != last_target);
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      wall_r  <= wall_time;
      idle_r  <= idle_total;
      cur_r   <= cpu_freq;
      prime_r <= !has_prior;
    end
    if (cmd.diff) begin
      dw  <= wall_r - last_wall;
      di  <= idle_r - last_idle;
      big <= ({1'b0, cfg.hw_max} > {cfg.hw_min, 1'b0});
    end
    if (cmd.check) begin
      bad  <= (dw == '0) || dd[lbfg_pkg::TIME_W];
      busy <= dd[lbfg_pkg::TIME_W-1:0];
      num  <= '0;
      quo  <= '0;
      dsr  <= {1'b0, dw, 6'd0};
    end
    // shift-add by the load scale, msb first
    if (cmd.mul) begin
      num <= {num[lbfg_pkg::NUM_W-2:0], 1'b0}
           + (lbfg_pkg::LOAD_SCALE[lbfg_pkg::LAST_STEP - cmd.step]
              ? {7'd0, busy} : '0);
    end
    // restoring divide, one quotient bit per step
    if (cmd.div) begin
      if (ge) begin
        num <= num - dsr;
      end
      quo <= {quo[5:0], ge};
      dsr <= dsr >> 1;
    end
    if (cmd.classify) begin
      load_r <= bad ? '0 : quo;
    end
    if (cmd.prod) begin
      fast      <= (load_r >= cfg.fast_ramp);
      med       <= (load_r > thr);
      prod      <= {7'd0, cfg.lim_max} * {24'd0, load_r};
      mx95      <= {7'd0, cfg.lim_max} * {24'd0, lbfg_pkg::CAP_PCT};
      cur_gt_mn <= (cur_r > cfg.lim_min);
      cm        <= cur_r - cfg.lim_min;
    end
    if (cmd.quot) begin
      adj    <= q_adj[23:0];
      cap    <= q_cap[23:0];
      step_a <= q_a[23:0];
      step_b <= q_b;
    end
    if (cmd.pick) begin
      tp      <= tp_pick;
      hold_nx <= hold_pick;
      delay_r <= (fast || med) ? lbfg_pkg::DELAY_FAST : lbfg_pkg::DELAY_SLOW;
    end
  end

  // governor state, updated when a result is committed
  always_ff @(posedge clk) begin
    if (rst) begin
      has_prior   <= 1'b0;
      last_wall   <= '0;
      last_idle   <= '0;
      last_target <= '0;
      heat        <= '0;
      hold        <= '0;
    end else if (cmd.commit) begin
      has_prior <= 1'b1;
      last_wall <= wall_r;
      last_idle <= idle_r;
      if (prime_r) begin
        last_target <= cur_r;
      end else begin
        if (req) begin
          last_target <= tgt;
        end
        heat <= heat_nx;
        hold <= hold_nx;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (prime_r) begin
        primed         <= 1'b0;
        request_valid  <= 1'b0;
        requested_freq <= '0;
        load_percent   <= '0;
        poll_delay     <= lbfg_pkg::DELAY_SLOW;
      end else begin
        primed         <= 1'b1;
        request_valid  <= req;
        requested_freq <= tgt;
        load_percent   <= load_r;
        poll_delay     <= delay_r;
      end
    end
  end

  // checks
  `LBFG_ASSERT_ALWAYS(a_hold_bound, clk, rst,
    hold <= lbfg_pkg::HOLD_LIMIT,
    "hold counter beyond its limit")
  `LBFG_ASSERT_NXT(a_load_range, clk, rst,
    cmd.classify, load_r <= lbfg_pkg::LOAD_SCALE,
    "load above one hundred percent")
  `LBFG_ASSERT_IMP(a_req_needs_prime, clk, rst,
    out_valid && request_valid, primed,
    "request issued on priming sample")

endmodule
